@@ rtl/mcs_pkg.sv @@
package mcs_pkg;

    // Supported function codes
    localparam logic [7:0] FN_READ_COILS    = 8'h01;
    localparam logic [7:0] FN_READ_INPUTS   = 8'h02;
    localparam logic [7:0] FN_WRITE_SINGLE  = 8'h05;
    localparam logic [7:0] FN_WRITE_MULTI   = 8'h0F;

    // Coil values for write single coil
    localparam logic [7:0] COIL_ON  = 8'hFF;
    localparam logic [7:0] COIL_OFF = 8'h00;

    localparam logic [7:0] BROADCAST_ADDR = 8'h00;

    // Configuration register reset values
    localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;
    localparam logic [7:0] INPUTS_RESET     = 8'b0000_1001;

    // Register index (paddr[2])
    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_INPUTS     = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_MULTI  = 2'd2,
        KIND_EXC    = 2'd3
    } reply_kind_t;

    typedef enum logic [1:0] {
        EXC_NONE     = 2'd0,
        EXC_FUNCTION = 2'd1,
        EXC_ADDRESS  = 2'd2,
        EXC_VALUE    = 2'd3
    } exc_kind_t;

    typedef struct packed {
        logic [7:0] dst_address;
        logic [7:0] function_code;
        logic [7:0] addr_hi;
        logic [7:0] addr_lo;
        logic [7:0] word_hi;
        logic [7:0] word_lo;
        logic [7:0] coil_bits;
    } req_t;

    typedef struct packed {
        reply_kind_t reply_kind;
        logic [7:0]  reply_function;
        exc_kind_t   exception_kind;
        logic [7:0]  read_bits;
        logic [15:0] echo_address;
        logic [15:0] echo_value;
        logic [7:0]  coil_image;
        logic [15:0] served_count;
    } rsp_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] discrete_inputs;
    } cfg_t;

endpackage

@@ rtl/mcs_regs.sv @@
module mcs_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output mcs_pkg::cfg_t                     cfg
);
    import mcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SLAVE_ADDR: cfg_next.slave_address   = pwdata[7:0];
                REG_INPUTS:     cfg_next.discrete_inputs = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address   <= SLAVE_ADDR_RESET;
            cfg_reg.discrete_inputs <= INPUTS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_SLAVE_ADDR: prdata = {24'h000000, cfg_reg.slave_address};
            REG_INPUTS:     prdata = {24'h000000, cfg_reg.discrete_inputs};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/mcs_exec.sv @@
module mcs_exec #(
    parameter int unsigned NUM_COILS = 8
) (
    input  mcs_pkg::req_t         req,
    input  mcs_pkg::cfg_t         cfg,
    input  logic [NUM_COILS-1:0]  coil_cur,
    input  logic [15:0]           count_cur,
    output logic                  hit,
    output logic [NUM_COILS-1:0]  coil_next,
    output mcs_pkg::rsp_t         rsp
);
    import mcs_pkg::*;

    localparam logic [8:0] NC        = 9'(NUM_COILS);
    localparam logic [7:0] COIL_MASK = 8'((9'd1 << NUM_COILS) - 9'd1);

    logic [7:0] coil8;
    logic [7:0] coil8_new;
    logic [7:0] src;
    logic [8:0] span;
    logic [8:0] qmask9;
    logic [7:0] qmask;
    logic [7:0] field;
    logic [7:0] sel;
    logic       range_bad;
    logic       alo_bad;

    assign hit   = (req.dst_address == cfg.slave_address) ||
                   (req.dst_address == BROADCAST_ADDR);
    assign coil8 = 8'(coil_cur);

    // Range checks
    assign span      = {1'b0, req.addr_lo} + {1'b0, req.word_lo};
    assign alo_bad   = ({1'b0, req.addr_lo} >= NC);
    assign range_bad = (req.addr_hi != 8'h00) || (req.word_hi != 8'h00) ||
                       alo_bad || (span > NC);

    // Quantity mask and bit positions; only meaningful when in range
    assign qmask9 = (9'd1 << req.word_lo[3:0]) - 9'd1;
    assign qmask  = qmask9[7:0];
    assign field  = (qmask << req.addr_lo[2:0]) & COIL_MASK;
    assign sel    = 8'd1 << req.addr_lo[2:0];
    assign src    = (req.function_code == FN_READ_COILS) ? coil8 : cfg.discrete_inputs;

    // Function decode
    always_comb
    begin
        rsp                = '0;
        rsp.reply_kind     = KIND_EXC;
        rsp.reply_function = req.function_code;
        rsp.exception_kind = EXC_NONE;
        coil8_new          = coil8;
        unique case (req.function_code)
            FN_READ_COILS, FN_READ_INPUTS:
            begin
                if (range_bad)
                    rsp.exception_kind = EXC_ADDRESS;
                else
                begin
                    rsp.read_bits  = (src >> req.addr_lo[2:0]) & qmask;
                    rsp.reply_kind = KIND_READ;
                end
            end
            FN_WRITE_SINGLE:
            begin
                if ((req.addr_hi != 8'h00) || (req.word_lo != 8'h00) || alo_bad)
                    rsp.exception_kind = EXC_ADDRESS;
                else if ((req.word_hi != COIL_ON) && (req.word_hi != COIL_OFF))
                    rsp.exception_kind = EXC_VALUE;
                else
                begin
                    if (req.word_hi == COIL_ON)
                        coil8_new = (coil8 | sel) & COIL_MASK;
                    else
                        coil8_new = coil8 & ~sel;
                    rsp.echo_address = {8'h00, req.addr_lo};
                    rsp.echo_value   = {req.word_hi, 8'h00};
                    rsp.reply_kind   = KIND_SINGLE;
                end
            end
            FN_WRITE_MULTI:
            begin
                if (range_bad)
                    rsp.exception_kind = EXC_ADDRESS;
                else
                begin
                    coil8_new = (coil8 & ~field) |
                                ((req.coil_bits << req.addr_lo[2:0]) & field);
                    rsp.echo_address = {8'h00, req.addr_lo};
                    rsp.echo_value   = {8'h00, req.word_lo};
                    rsp.reply_kind   = KIND_MULTI;
                end
            end
            default:
            begin
                rsp.exception_kind = EXC_FUNCTION;
            end
        endcase
        // A dropped request leaves the coils alone
        if (!hit)
            coil8_new = coil8;
        rsp.coil_image   = coil8_new;
        rsp.served_count = (rsp.reply_kind != KIND_EXC) ? count_cur + 16'd1 : count_cur;
    end

    assign coil_next = coil8_new[NUM_COILS-1:0];

endmodule

@@ rtl/modbus_coil_slave_handler.sv @@
// Channel | Valid     | Stall     | Payload            | Notes
// --------+-----------+-----------+--------------------+---------------------------
// request | req_valid | req_stall | req  (mcs_pkg::req_t) | one deframed request
// reply   | rsp_valid | rsp_stall | rsp  (mcs_pkg::rsp_t) | zero or one per request
// config  | psel/penable/pwrite | pready=1 | paddr, pwdata, prdata | APB regs
//
// An accepted request passes from the input register through one evaluation
// pass into the reply register, which also commits the coil and counter state.
// One request per cycle is sustained while rsp_stall is low.
// Requests for another station are dropped in the evaluation stage.
// Reset clears coils and counter; registers return to address 1, inputs 9.
// rsp_stall backs up into req_stall only when both stages hold a request.
module modbus_coil_slave_handler #(
    parameter int unsigned NUM_COILS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  mcs_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output mcs_pkg::rsp_t                     rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mcs_pkg::*;

    cfg_t                 cfg;
    logic                 in_valid_reg;
    req_t                 in_data_reg;
    logic                 out_valid_reg;
    rsp_t                 out_data_reg;
    logic [NUM_COILS-1:0] coil_reg;
    logic [NUM_COILS-1:0] coil_next;
    logic [15:0]          count_reg;
    logic                 hit;
    rsp_t                 rsp_next;
    logic                 consume;
    logic                 out_free;

    mcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcs_exec #(
        .NUM_COILS (NUM_COILS)
    ) u_exec (
        .req       (in_data_reg),
        .cfg       (cfg),
        .coil_cur  (coil_reg),
        .count_cur (count_reg),
        .hit       (hit),
        .coil_next (coil_next),
        .rsp       (rsp_next)
    );

    // Stage handshake: a dropped request needs no reply slot
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign consume   = in_valid_reg && (!hit || out_free);
    assign req_stall = in_valid_reg && !consume;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!req_stall)
            in_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_data_reg <= req;
    end

    // Reply register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= consume && hit;
    end

    always_ff @(posedge clk)
    begin
        if (consume && hit)
            out_data_reg <= rsp_next;
    end

    // Coil and counter state commit with the reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg  <= '0;
            count_reg <= 16'h0000;
        end
        else if (consume && hit)
        begin
            coil_reg  <= coil_next;
            count_reg <= rsp_next.served_count;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

@@ rtl/mcs_checker.sv @@
module mcs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_stall,
    input mcs_pkg::rsp_t                     rsp
);
    import mcs_pkg::*;

    logic        rsp_fire;
    logic        seen_reg;
    logic [15:0] last_count_reg;

    assign rsp_fire = rsp_valid && !rsp_stall;

    // Served count of the last delivered reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_count_reg <= 16'h0000;
        end
        else if (rsp_fire)
        begin
            seen_reg       <= 1'b1;
            last_count_reg <= rsp.served_count;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("reply dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("reply changed while stalled");

    a_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.reply_kind == KIND_EXC) == (rsp.exception_kind != EXC_NONE)))
        else $error("exception code does not match reply kind");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.reply_kind != KIND_READ) |-> (rsp.read_bits == 8'h00))
        else $error("read bits set on non-read reply");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && seen_reg |->
            (rsp.served_count == last_count_reg +
                ((rsp.reply_kind != KIND_EXC) ? 16'd1 : 16'd0)))
        else $error("served count out of step");

endmodule

bind modbus_coil_slave_handler mcs_checker u_mcs_checker (.*);
